[src/c2dsz_pkg.sv]
`timescale 1ns / 1ps
package c2dsz_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_K    = 5;
    localparam int MAX_RESULTS  = 3;
    localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] FUNC_TAP   = 2'd0;
    localparam logic [1:0] FUNC_PIX   = 2'd1;
    localparam logic [1:0] FUNC_FLUSH = 2'd2;

    localparam logic [1:0] REG_IMG_ROWS = 2'd0;
    localparam logic [1:0] REG_IMG_COLS = 2'd1;
    localparam logic [1:0] REG_KER_ROWS = 2'd2;
    localparam logic [1:0] REG_KER_COLS = 2'd3;

    typedef struct packed {
        logic [1:0]                 func;
        logic [4:0]                 tap_index;
        logic signed [SAMPLE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_value;
        logic [15:0]                out_row;
        logic [9:0]                 out_col;
        logic                       last_of_run;
        logic                       frame_done;
    } out_item_t;

    typedef struct packed {
        logic write_tap;
        logic write_pix;
        logic start_out;
        logic step;
        logic emit;
        logic last;
        logic advance_in;
    } dp_cmd_t;

    typedef struct packed {
        logic tap_ok;
        logic is_pixel;
        logic ready_now;
        logic ready_next;
        logic tap_last;
        logic out_free;
    } dp_stat_t;

endpackage

[src/c2dsz_ram.sv]
`timescale 1ns / 1ps
module c2dsz_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[src/c2dsz_ctrl.sv]
`timescale 1ns / 1ps
module c2dsz_ctrl
    import c2dsz_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_MAC   = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic       last_reg, last_next;
    logic       drain_reg, drain_next;
    logic       accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        last_next  = last_reg;
        drain_next = drain_reg;
        cmd        = '0;
        cmd.last   = last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.func)
                        FUNC_TAP: begin
                            cmd.write_tap = stat.tap_ok;
                        end
                        FUNC_PIX, FUNC_FLUSH: begin
                            if (s_data.func == FUNC_PIX || !stat.is_pixel) begin
                                cmd.write_pix = stat.is_pixel;
                                n_next        = '0;
                                state_next    = ST_CHECK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                if (32'(n_reg) < MAX_RESULTS && stat.ready_now) begin
                    cmd.start_out = 1'b1;
                    last_next     = (32'(n_reg) == MAX_RESULTS - 1) || !stat.ready_next;
                    state_next    = ST_MAC;
                end else begin
                    cmd.advance_in = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_MAC: begin
                cmd.step = 1'b1;
                if (stat.tap_last) begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                drain_next = 1'b1;
                if (drain_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hold until the output register can take the item
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    n_next     = n_reg + 1'b1;
                    state_next = ST_CHECK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            last_reg  <= 1'b0;
            drain_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
            last_reg  <= last_next;
            drain_reg <= drain_next;
        end
    end
endmodule

[src/c2dsz_dp.sv]
`timescale 1ns / 1ps
module c2dsz_dp
    import c2dsz_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_K    = DEF_MAX_K
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  in_item_t    s_data,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata
);
    localparam int NT    = MAX_K * MAX_K;
    localparam int TIW   = (NT > 1) ? $clog2(NT) : 1;
    localparam int DEPTH = MAX_K * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int KW    = $clog2(MAX_K + 1);
    localparam int SW    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int RW    = $clog2(65536 + MAX_K);

    // configuration
    logic [15:0] img_rows_reg;
    logic [10:0] img_cols_reg;
    logic [2:0]  ker_rows_reg, ker_cols_reg;
    logic        cfg_wr;

    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_rows_reg <= 16'd1;
            img_cols_reg <= 11'd1;
            ker_rows_reg <= 3'd3;
            ker_cols_reg <= 3'd3;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_IMG_ROWS: img_rows_reg <= pwdata[15:0];
                REG_IMG_COLS: img_cols_reg <= pwdata[10:0];
                REG_KER_ROWS: ker_rows_reg <= pwdata[2:0];
                REG_KER_COLS: ker_cols_reg <= pwdata[2:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_IMG_ROWS: prdata = 32'(img_rows_reg);
            REG_IMG_COLS: prdata = 32'(img_cols_reg);
            REG_KER_ROWS: prdata = 32'(ker_rows_reg);
            REG_KER_COLS: prdata = 32'(ker_cols_reg);
            default:      prdata = '0;
        endcase
    end

    // effective sizes
    logic [15:0]   rows;
    logic [CW-1:0] cols;
    logic [KW-1:0] kr, kc, pr, pc, dr, dc;

    always_comb begin
        rows = (img_rows_reg == '0) ? 16'd1 : img_rows_reg;
        if (img_cols_reg == '0) begin
            cols = CW'(1);
        end else if (32'(img_cols_reg) > MAX_COLS) begin
            cols = CW'(MAX_COLS);
        end else begin
            cols = CW'(img_cols_reg);
        end
        if (ker_rows_reg == '0) begin
            kr = KW'(1);
        end else if (32'(ker_rows_reg) > MAX_K) begin
            kr = KW'(MAX_K);
        end else begin
            kr = KW'(ker_rows_reg);
        end
        if (ker_cols_reg == '0) begin
            kc = KW'(1);
        end else if (32'(ker_cols_reg) > MAX_K) begin
            kc = KW'(MAX_K);
        end else begin
            kc = KW'(ker_cols_reg);
        end
        pr = (kr - 1'b1) >> 1;
        pc = (kc - 1'b1) >> 1;
        dr = kr - 1'b1 - pr;
        dc = kc - 1'b1 - pc;
    end

    // kernel taps
    logic signed [SAMPLE_W-1:0] ker_reg [NT];
    logic                       tap_ok;

    assign tap_ok = 32'(s_data.tap_index) < NT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NT; i++) begin
                ker_reg[i] <= '0;
            end
        end else if (cmd.write_tap) begin
            ker_reg[TIW'(s_data.tap_index)] <= s_data.value;
        end
    end

    // raster counters
    logic [RW-1:0] in_row_reg, nor_reg;
    logic [CW-1:0] in_col_reg, noc_reg;
    logic [SW-1:0] in_slot_reg, out_slot_reg;
    logic          restart;

    logic [RW-1:0] nor_adv;
    logic [CW-1:0] noc_adv;
    logic [SW-1:0] out_slot_adv;
    logic          nor_ok_adv;

    always_comb begin
        if (noc_reg + 1'b1 >= cols) begin
            noc_adv      = '0;
            nor_adv      = nor_reg + 1'b1;
            out_slot_adv = (32'(out_slot_reg) == MAX_K - 1) ? '0 : out_slot_reg + 1'b1;
        end else begin
            noc_adv      = noc_reg + 1'b1;
            nor_adv      = nor_reg;
            out_slot_adv = out_slot_reg;
        end
        nor_ok_adv = nor_adv < RW'(rows);
    end

    function automatic logic win_ready(input logic [RW-1:0] r, input logic [CW-1:0] c,
                                       input logic [RW-1:0] ir, input logic [CW-1:0] icol,
                                       input logic [KW-1:0] d_r, input logic [KW-1:0] d_c,
                                       input logic [CW-1:0] ncols);
        logic [RW:0] need_r;
        logic [CW:0] need_c;
        need_r = {1'b0, r} + (RW + 1)'(d_r);
        need_c = {1'b0, c} + (CW + 1)'(d_c);
        if (need_c > {1'b0, ncols - 1'b1}) begin
            need_c = {1'b0, ncols - 1'b1};
        end
        return (need_r < {1'b0, ir}) || (need_r == {1'b0, ir} && need_c <= {1'b0, icol});
    endfunction

    assign restart = cfg_wr || (cmd.advance_in && !(nor_reg < RW'(rows)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            nor_reg      <= '0;
            noc_reg      <= '0;
            out_slot_reg <= '0;
        end else if (restart) begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            nor_reg      <= '0;
            noc_reg      <= '0;
            out_slot_reg <= '0;
        end else begin
            if (cmd.advance_in) begin
                if (in_col_reg + 1'b1 >= cols) begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_reg + 1'b1;
                    in_slot_reg <= (32'(in_slot_reg) == MAX_K - 1) ? '0 : in_slot_reg + 1'b1;
                end else begin
                    in_col_reg <= in_col_reg + 1'b1;
                end
            end
            if (cmd.emit) begin
                nor_reg      <= nor_adv;
                noc_reg      <= noc_adv;
                out_slot_reg <= out_slot_adv;
            end
        end
    end

    // tap walk
    logic [KW-1:0]  ki_reg, kj_reg;
    logic [TIW-1:0] tidx_reg;
    logic [SW-1:0]  rs_reg;
    logic [SW:0]    rs_start;
    logic signed [RW+1:0] ir;
    logic signed [CW+1:0] ic;
    logic           in_img;
    logic [AW-1:0]  raddr, waddr;

    always_comb begin
        rs_start = (SW + 1)'(out_slot_reg) + (SW + 1)'(MAX_K) - (SW + 1)'(pr);
        if (32'(rs_start) >= MAX_K) begin
            rs_start = rs_start - (SW + 1)'(MAX_K);
        end
        ir = $signed({2'b00, nor_reg}) + $signed((RW + 2)'(ki_reg))
             - $signed((RW + 2)'(pr));
        ic = $signed({2'b00, noc_reg}) + $signed((CW + 2)'(kj_reg))
             - $signed((CW + 2)'(pc));
        in_img = (ir >= 0) && (ir < $signed((RW + 2)'(rows)))
                 && (ic >= 0) && (ic < $signed((CW + 2)'(cols)));
        raddr = AW'(32'(rs_reg) * MAX_COLS + (in_img ? 32'(ic[CW-1:0]) : 32'd0));
        waddr = AW'(32'(in_slot_reg) * MAX_COLS + 32'(in_col_reg));
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_out) begin
            ki_reg   <= '0;
            kj_reg   <= '0;
            tidx_reg <= '0;
            rs_reg   <= SW'(rs_start);
        end else if (cmd.step) begin
            tidx_reg <= tidx_reg + 1'b1;
            if (kj_reg == kc - 1'b1) begin
                kj_reg <= '0;
                ki_reg <= ki_reg + 1'b1;
                rs_reg <= (32'(rs_reg) == MAX_K - 1) ? '0 : rs_reg + 1'b1;
            end else begin
                kj_reg <= kj_reg + 1'b1;
            end
        end
    end

    // line store
    logic [SAMPLE_W-1:0] rdata;

    c2dsz_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_line (
        .aclk (aclk),
        .we   (cmd.write_pix),
        .waddr(waddr),
        .wdata(s_data.value),
        .raddr(raddr),
        .rdata(rdata)
    );

    // multiply-accumulate pipeline
    logic                         v1_reg, v2_reg;
    logic signed [SAMPLE_W-1:0]   tap1_reg;
    logic signed [2*SAMPLE_W-1:0] prod_reg;
    logic [SAMPLE_W-1:0]          acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.step && in_img;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        tap1_reg <= ker_reg[tidx_reg];
        prod_reg <= $signed(rdata) * tap1_reg;
        if (cmd.start_out) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + prod_reg[SAMPLE_W-1:0];
        end
    end

    // output register
    logic      m_valid_reg;
    out_item_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg.out_value   <= $signed(acc_reg);
            m_data_reg.out_row     <= 16'(nor_reg);
            m_data_reg.out_col     <= 10'(noc_reg);
            m_data_reg.last_of_run <= cmd.last;
            m_data_reg.frame_done  <= (nor_reg == RW'(rows - 1'b1))
                                      && (noc_reg == cols - 1'b1);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        stat.tap_ok     = tap_ok;
        stat.is_pixel   = in_row_reg < RW'(rows);
        stat.ready_now  = (nor_reg < RW'(rows))
                          && win_ready(nor_reg, noc_reg, in_row_reg, in_col_reg, dr, dc, cols);
        stat.ready_next = nor_ok_adv
                          && win_ready(nor_adv, noc_adv, in_row_reg, in_col_reg, dr, dc, cols);
        stat.tap_last   = (ki_reg == kr - 1'b1) && (kj_reg == kc - 1'b1);
        stat.out_free   = !m_valid_reg || m_ready;
    end
endmodule

[src/conv2d_same_zero_pad.sv]
`timescale 1ns / 1ps
// Channel  Ports               Payload     Accepted when
// input    s_valid / s_ready   in_item_t   s_valid && s_ready
// result   m_valid / m_ready   out_item_t  m_valid && m_ready
// config   psel/penable/pwrite 32-bit APB  psel && penable && pwrite (pready tied high)
//
// A tap write or an ignored item leaves the controller idle. A pixel or flush item
// holds s_ready low while, for each output it releases, a multiply-accumulate
// walks the window taps through the line store read port.
// Reset is synchronous and clears the kernel and raster counters; the line store is not cleared.
// A stalled result waits in the output register; the next output waits for it.
module conv2d_same_zero_pad
    import c2dsz_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_K    = DEF_MAX_K
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign pready = 1'b1;

    c2dsz_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .stat   (stat),
        .cmd    (cmd)
    );

    c2dsz_dp #(
        .MAX_COLS(MAX_COLS),
        .MAX_K   (MAX_K)
    ) u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_data (s_data),
        .cmd    (cmd),
        .stat   (stat),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata)
    );
endmodule

[dv/tb_conv2d_same_zero_pad.sv]
`timescale 1ns / 1ps
module tb_conv2d_same_zero_pad;
    import c2dsz_pkg::*;

    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int         TAPS      = DEF_MAX_K * DEF_MAX_K;

    class conv_scoreboard;
        logic [15:0] taps [TAPS];
        logic [15:0] lines [DEF_MAX_K][DEF_MAX_COLS];
        int unsigned in_row, in_col, out_row, out_col;
        bit [15:0]   img_rows;
        bit [10:0]   img_cols;
        bit [2:0]    ker_rows, ker_cols;
        out_item_t   pending[$];
        bit          failed;

        function void clear();
            foreach (taps[i]) taps[i] = '0;
            restart();
            img_rows = 1;
            img_cols = 1;
            ker_rows = 3;
            ker_cols = 3;
            pending.delete();
            failed = 0;
        endfunction

        function void restart();
            in_row = 0;
            in_col = 0;
            out_row = 0;
            out_col = 0;
        endfunction

        function void write_reg(logic [1:0] idx, bit [31:0] val);
            case (idx)
                REG_IMG_ROWS: img_rows = val[15:0];
                REG_IMG_COLS: img_cols = val[10:0];
                REG_KER_ROWS: ker_rows = val[2:0];
                REG_KER_COLS: ker_cols = val[2:0];
                default: ;
            endcase
            restart();
        endfunction

        function logic [15:0] window_sum(int unsigned r, int unsigned c, int unsigned rows,
                                         int unsigned cols, int unsigned kr, int unsigned kc);
            int acc;
            int ir, ic;
            acc = 0;
            for (int ki = 0; ki < kr; ki++) begin
                ir = int'(r) + ki - (int'(kr) - 1) / 2;
                if (ir < 0 || ir >= int'(rows)) continue;
                for (int kj = 0; kj < kc; kj++) begin
                    ic = int'(c) + kj - (int'(kc) - 1) / 2;
                    if (ic < 0 || ic >= int'(cols)) continue;
                    acc += int'($signed(lines[ir % DEF_MAX_K][ic]))
                         * int'($signed(taps[ki * kc + kj]));
                end
            end
            return acc[15:0];
        endfunction

        function void note_input(in_item_t it);
            int unsigned rows, cols, kr, kc, dr, dc, need_c, cur, need, n;
            bit          is_pix;
            out_item_t   o;
            rows = (img_rows == 0) ? 1 : img_rows;
            cols = (img_cols == 0) ? 1 : (img_cols > DEF_MAX_COLS ? DEF_MAX_COLS : img_cols);
            kr = (ker_rows == 0) ? 1 : (ker_rows > DEF_MAX_K ? DEF_MAX_K : ker_rows);
            kc = (ker_cols == 0) ? 1 : (ker_cols > DEF_MAX_K ? DEF_MAX_K : ker_cols);
            dr = kr - 1 - (kr - 1) / 2;
            dc = kc - 1 - (kc - 1) / 2;
            if (it.func == FUNC_TAP) begin
                if (it.tap_index < TAPS) taps[it.tap_index] = it.value;
                return;
            end
            if (it.func == FUNC_NONE) return;
            is_pix = in_row < rows;
            if (it.func == FUNC_FLUSH && is_pix) return;
            if (is_pix) lines[in_row % DEF_MAX_K][in_col] = it.value;
            cur = in_row * cols + in_col;
            n = 0;
            while (n < MAX_RESULTS && out_row < rows) begin
                need_c = out_col + dc;
                if (need_c > cols - 1) need_c = cols - 1;
                need = (out_row + dr) * cols + need_c;
                if (need > cur) break;
                o.out_value   = window_sum(out_row, out_col, rows, cols, kr, kc);
                o.out_row     = out_row[15:0];
                o.out_col     = out_col[9:0];
                o.last_of_run = 1'b0;
                o.frame_done  = (out_row == rows - 1 && out_col == cols - 1);
                pending.push_back(o);
                n++;
                out_col++;
                if (out_col >= cols) begin
                    out_col = 0;
                    out_row++;
                end
            end
            in_col++;
            if (in_col >= cols) begin
                in_col = 0;
                in_row++;
            end
            if (out_row >= rows) restart();
            if (n > 0) pending[pending.size() - 1].last_of_run = 1'b1;
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                failed = 1;
                return;
            end
            want = pending.pop_front();
            if (got.out_value !== want.out_value || got.out_row !== want.out_row ||
                got.out_col !== want.out_col || got.last_of_run !== want.last_of_run ||
                got.frame_done !== want.frame_done) begin
                $display("%0t: mismatch expected %p actual %p", $time, want, got);
                failed = 1;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    conv_scoreboard sb;
    bit             calm;
    int             sent;

    conv2d_same_zero_pad dut (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stall, check at the falling edge before acceptance
    always @(posedge aclk) m_ready <= calm || ($urandom_range(99) >= 38);

    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    task automatic send(in_item_t it);
        while (!calm && $urandom_range(99) < 38) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        sb.note_input(it);
        sent++;
    endtask

    task automatic send_fields(logic [1:0] f, logic [4:0] idx, logic [15:0] v);
        in_item_t it;
        it.func = f;
        it.tap_index = idx;
        it.value = v;
        send(it);
    endtask

    // hold off until every result is in, then let the last walk finish
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, bit [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic set_shape(bit [31:0] rows, bit [31:0] cols, bit [31:0] kr, bit [31:0] kc);
        drain();
        write_reg(REG_IMG_ROWS, rows);
        write_reg(REG_IMG_COLS, cols);
        write_reg(REG_KER_ROWS, kr);
        write_reg(REG_KER_COLS, kc);
    endtask

    // kernel, one frame with some noise, then enough positions below the image
    task automatic run_frame(int rows, int cols, int kr, int kc);
        for (int i = 0; i < kr * kc; i++)
            send_fields(FUNC_TAP, 5'(i), 16'($urandom));
        if ($urandom_range(3) == 0)
            send_fields(FUNC_TAP, 5'($urandom_range(31)), 16'($urandom));
        for (int i = 0; i < rows * cols; i++) begin
            case ($urandom_range(19))
                0: send_fields(FUNC_NONE, 5'($urandom), 16'($urandom));
                1: send_fields(FUNC_FLUSH, 5'($urandom), 16'($urandom));
                2: send_fields(FUNC_TAP, 5'($urandom_range(TAPS - 1)), 16'($urandom));
                default: ;
            endcase
            send_fields(FUNC_PIX, 5'($urandom), 16'($urandom));
        end
        for (int i = 0; i <= kr * cols; i++)
            send_fields($urandom_range(1) ? FUNC_FLUSH : FUNC_PIX, 5'($urandom),
                        16'($urandom));
    endtask

    initial begin
        int r, c, kr, kc;
        int phase;
        sb = new();
        sb.clear();
        calm = 0;
        sent = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset shape: one pixel, 3x3 kernel
        send_fields(FUNC_TAP, 5'd4, 16'h7fff);
        send_fields(FUNC_TAP, 5'd0, 16'h8000);
        send_fields(FUNC_TAP, 5'd31, 16'h1234);
        send_fields(FUNC_TAP, 5'd25, 16'hffff);
        send_fields(FUNC_NONE, 5'd0, 16'h5555);
        send_fields(FUNC_FLUSH, 5'd0, 16'h0000);
        send_fields(FUNC_PIX, 5'd0, 16'h7fff);
        send_fields(FUNC_FLUSH, 5'd0, 16'h0000);
        send_fields(FUNC_PIX, 5'd0, 16'h8000);
        send_fields(FUNC_PIX, 5'd0, 16'hffff);
        send_fields(FUNC_TAP, 5'd24, 16'h8000);

        set_shape(3, 4, 5, 5);
        run_frame(3, 4, 5, 5);
        set_shape(2, 5, 2, 4);
        run_frame(2, 5, 2, 4);
        set_shape(0, 0, 0, 0);
        run_frame(1, 1, 1, 1);
        set_shape(2, 3, 7, 7);
        run_frame(2, 3, 5, 5);
        set_shape(1, 2047, 1, 5);
        for (int i = 0; i < 8; i++) send_fields(FUNC_PIX, 5'd0, 16'($urandom));
        set_shape(65535, 3, 1, 2);
        for (int i = 0; i < 8; i++) send_fields(FUNC_PIX, 5'd0, 16'($urandom));

        phase = 0;
        while (sent < 250) begin
            r  = $urandom_range(1, 4);
            c  = $urandom_range(1, 6);
            kr = ($urandom_range(7) == 0) ? $urandom_range(1) * 7 : $urandom_range(1, 5);
            kc = ($urandom_range(7) == 0) ? $urandom_range(1) * 7 : $urandom_range(1, 5);
            set_shape(r, c, kr, kc);
            calm = (phase <= 1);
            run_frame(r, c, (kr == 0) ? 1 : (kr > 5 ? 5 : kr),
                      (kc == 0) ? 1 : (kc > 5 ? 5 : kc));
            phase++;
        end
        calm = 0;
        drain();

        if (sb.failed)
            $display("CHECK FAILED");
        else
            $display("CHECK OK");
        $finish;
    end

endmodule
